@@ rtl/lie_pkg.sv @@
// Package for the Lagrange interpolation engine: op and status codes,
// saturation bound and default sizes. No dependencies.
package lie_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  typedef logic [1:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_EVAL  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_DUP   = 3'd1;
  localparam status_t ST_RANGE = 3'd2;
  localparam status_t ST_FEW   = 3'd3;
  localparam status_t ST_FULL  = 3'd4;
  localparam status_t ST_SAT   = 3'd5;

  // Intermediate magnitude bound, 2^62-1.
  localparam logic [63:0] SAT_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

endpackage

@@ rtl/lagrange_interpolation_engine_core.sv @@
// Lagrange interpolation engine, top level: node store, sequencer, shared
// restoring divider and 32x32 partial-product multiplier.
// Depends on lie_pkg.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   input   | in_valid/in_ready, op, x_value, fx_value        | in
//   result  | out_valid/out_ready, result_value, status       | out
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Load: a scan of the n stored nodes for a duplicate, then the write.
// Evaluate: the same duplicate scan and a range check; each pair (i,j) costs
// a fetch, a 64-step divide on the shared divider, four partial products
// on the shared 32x32 multiplier and a write-back.
// Clear, unused op and too few points go straight to the result register.
// rst (synchronous) empties the table; node memories are not cleared.
// A finished result waits in the output register; the next item may be taken
// meanwhile, and it stalls only in its last cycle if that register is full.
module lagrange_interpolation_engine_core #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = lie_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] fx_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [2:0]         status
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);
  localparam logic [63:0]  ONE   = 64'(1) << FRAC_BITS;
  localparam logic [127:0] RHALF = 128'(1) << (FRAC_BITS - 1);

  // sequencer codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SCAN_A  = 5'd1;
  localparam logic [4:0] S_SCAN_W  = 5'd2;
  localparam logic [4:0] S_SCAN_C  = 5'd3;
  localparam logic [4:0] S_LOAD    = 5'd4;
  localparam logic [4:0] S_RANGE   = 5'd5;
  localparam logic [4:0] S_EVI_A   = 5'd6;
  localparam logic [4:0] S_EVI_W   = 5'd7;
  localparam logic [4:0] S_EVI_C   = 5'd8;
  localparam logic [4:0] S_EVJ     = 5'd9;
  localparam logic [4:0] S_EVJ_W   = 5'd10;
  localparam logic [4:0] S_EVJ_C   = 5'd11;
  localparam logic [4:0] S_DIV     = 5'd12;
  localparam logic [4:0] S_DIV_END = 5'd13;
  localparam logic [4:0] S_MUL     = 5'd14;
  localparam logic [4:0] S_MUL_ADD = 5'd15;
  localparam logic [4:0] S_MUL_END = 5'd16;
  localparam logic [4:0] S_TERM    = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0] state;

  // item registers
  lie_pkg::op_t      op_reg;
  logic signed [31:0] x_reg;
  logic signed [31:0] fx_reg;

  // table state
  logic [CW-1:0]      count;
  logic signed [31:0] least_x;
  logic signed [31:0] greatest_x;
  logic [31:0]        node_x  [MAX_POINTS];
  logic [31:0]        node_fx [MAX_POINTS];
  logic [IW-1:0]      addr;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_fx;

  // evaluation state
  logic [CW-1:0]      i_idx;
  logic [CW-1:0]      j_idx;
  logic signed [31:0] xi;
  logic signed [31:0] fi;
  logic signed [63:0] w;
  logic signed [63:0] acc;
  logic               sat;
  logic               term_pass;

  // divider
  logic [63:0] nq;
  logic [32:0] rem;
  logic [32:0] dvs;
  logic        dneg;
  logic        dzero;
  logic [5:0]  dcnt;

  // multiplier
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         mneg;
  logic [1:0]   mcnt;
  logic [63:0]  pp;
  logic [127:0] macc;

  // finished result
  logic signed [31:0]  fin_value;
  lie_pkg::status_t    fin_status;

  // combinational helpers
  logic signed [32:0] nd;
  logic signed [32:0] dd;
  logic [32:0]        un;
  logic [32:0]        ud;
  logic [63:0]        num;
  logic [33:0]        rem_sh;
  logic               qbit;
  logic [63:0]        qcap;
  logic               qover;
  logic [63:0]        wmag;
  logic [63:0]        fimag;
  logic [31:0]        pa;
  logic [31:0]        pb;
  logic [127:0]       pp_sh;
  logic [127:0]       mres_full;
  logic               mover;
  logic [63:0]        mmag;
  logic signed [63:0] tsum;

  always_comb begin
    nd    = {x_reg[31], x_reg} - {rd_x[31], rd_x};
    dd    = {xi[31], xi} - {rd_x[31], rd_x};
    un    = nd[32] ? 33'(-nd) : 33'(nd);
    ud    = dd[32] ? 33'(-dd) : 33'(dd);
    num   = ({31'd0, un} << FRAC_BITS) + {32'd0, ud[32:1]};
    rem_sh = {rem, nq[63]};
    qbit  = rem_sh >= {1'b0, dvs};
    qover = nq > lie_pkg::SAT_CAP;
    qcap  = dzero ? 64'd0 : (qover ? lie_pkg::SAT_CAP : nq);
    wmag  = w[63] ? 64'(-w) : 64'(w);
    fimag = fi[31] ? 64'(-{{32{fi[31]}}, fi}) : {32'd0, fi};
    pa    = mcnt[1] ? ma[63:32] : ma[31:0];
    pb    = mcnt[0] ? mb[63:32] : mb[31:0];
    case (mcnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    mres_full = macc >> FRAC_BITS;
    mover     = mres_full > {64'd0, lie_pkg::SAT_CAP};
    mmag      = mover ? lie_pkg::SAT_CAP : mres_full[63:0];
    tsum      = acc + w;
  end

  assign in_ready = (state == S_IDLE);

  // node memories: one write port, registered read
  always_ff @(posedge clk) begin
    rd_x  <= node_x[addr];
    rd_fx <= node_fx[addr];
    if (state == S_LOAD && count < CW'(MAX_POINTS)) begin
      node_x[count[IW-1:0]]  <= x_reg;
      node_fx[count[IW-1:0]] <= fx_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count      <= '0;
      least_x    <= '0;
      greatest_x <= '0;
    end else begin
      // result taken; S_DONE refills the register itself
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_reg     <= op;
            x_reg      <= x_value;
            fx_reg     <= fx_value;
            j_idx      <= '0;
            fin_value  <= '0;
            fin_status <= lie_pkg::ST_OK;
            if (op == lie_pkg::OP_LOAD) begin
              state <= S_SCAN_A;
            end else if (op == lie_pkg::OP_EVAL) begin
              if (count < CW'(2)) begin
                fin_status <= lie_pkg::ST_FEW;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN_A;
              end
            end else begin
              if (op == lie_pkg::OP_CLEAR) begin
                count      <= '0;
                least_x    <= '0;
                greatest_x <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        // duplicate scan over stored nodes
        S_SCAN_A: begin
          if (j_idx == count) begin
            state <= (op_reg == lie_pkg::OP_LOAD) ? S_LOAD : S_RANGE;
          end else begin
            addr  <= j_idx[IW-1:0];
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: state <= S_SCAN_C;
        S_SCAN_C: begin
          if (rd_x == x_reg) begin
            fin_status <= lie_pkg::ST_DUP;
            state      <= S_DONE;
          end else begin
            j_idx <= j_idx + CW'(1);
            state <= S_SCAN_A;
          end
        end
        S_LOAD: begin
          if (count >= CW'(MAX_POINTS)) begin
            fin_status <= lie_pkg::ST_FULL;
          end else begin
            if (count == '0) begin
              least_x    <= x_reg;
              greatest_x <= x_reg;
            end else if (x_reg < least_x) begin
              least_x <= x_reg;
            end else if (x_reg > greatest_x) begin
              greatest_x <= x_reg;
            end
            count <= count + CW'(1);
          end
          state <= S_DONE;
        end
        S_RANGE: begin
          if (x_reg < least_x || x_reg > greatest_x) begin
            fin_status <= lie_pkg::ST_RANGE;
            state      <= S_DONE;
          end else begin
            acc   <= '0;
            sat   <= 1'b0;
            i_idx <= '0;
            state <= S_EVI_A;
          end
        end
        // outer loop: fetch node i
        S_EVI_A: begin
          if (i_idx == count) begin
            state <= S_FIN;
          end else begin
            addr  <= i_idx[IW-1:0];
            state <= S_EVI_W;
          end
        end
        S_EVI_W: state <= S_EVI_C;
        S_EVI_C: begin
          xi    <= rd_x;
          fi    <= rd_fx;
          w     <= $signed(ONE);
          j_idx <= '0;
          state <= S_EVJ;
        end
        // inner loop over j
        S_EVJ: begin
          if (j_idx == count) begin
            ma        <= wmag;
            mb        <= fimag;
            mneg      <= w[63] ^ fi[31];
            mcnt      <= '0;
            macc      <= RHALF;
            term_pass <= 1'b1;
            state     <= S_MUL;
          end else if (j_idx == i_idx) begin
            j_idx <= j_idx + CW'(1);
          end else begin
            addr  <= j_idx[IW-1:0];
            state <= S_EVJ_W;
          end
        end
        S_EVJ_W: state <= S_EVJ_C;
        S_EVJ_C: begin
          nq    <= num;
          rem   <= '0;
          dvs   <= ud;
          dneg  <= nd[32] ^ dd[32];
          dzero <= (ud == '0);
          dcnt  <= '1;
          state <= S_DIV;
        end
        // restoring divide, one quotient bit a cycle
        S_DIV: begin
          rem  <= qbit ? 33'(rem_sh - {1'b0, dvs}) : rem_sh[32:0];
          nq   <= {nq[62:0], qbit};
          dcnt <= dcnt - 6'd1;
          if (dcnt == '0) state <= S_DIV_END;
        end
        S_DIV_END: begin
          if (qover && !dzero) sat <= 1'b1;
          ma        <= wmag;
          mb        <= qcap;
          mneg      <= w[63] ^ (dneg && qcap != '0);
          mcnt      <= '0;
          macc      <= RHALF;
          term_pass <= 1'b0;
          state     <= S_MUL;
        end
        // four 32x32 partial products into a 128-bit accumulator
        S_MUL: begin
          pp    <= 64'(pa * pb);
          state <= S_MUL_ADD;
        end
        S_MUL_ADD: begin
          macc <= macc + pp_sh;
          mcnt <= mcnt + 2'd1;
          state <= (mcnt == 2'd3) ? S_MUL_END : S_MUL;
        end
        S_MUL_END: begin
          if (mover) sat <= 1'b1;
          w <= mneg ? $signed(64'(-mmag)) : $signed(mmag);
          if (term_pass) begin
            state <= S_TERM;
          end else begin
            j_idx <= j_idx + CW'(1);
            state <= S_EVJ;
          end
        end
        S_TERM: begin
          if (tsum > $signed(lie_pkg::SAT_CAP)) begin
            acc <= $signed(lie_pkg::SAT_CAP);
            sat <= 1'b1;
          end else if (tsum < -$signed(lie_pkg::SAT_CAP)) begin
            acc <= -$signed(lie_pkg::SAT_CAP);
            sat <= 1'b1;
          end else begin
            acc <= tsum;
          end
          i_idx <= i_idx + CW'(1);
          state <= S_EVI_A;
        end
        S_FIN: begin
          if (acc > 64'sh7FFF_FFFF) begin
            fin_value  <= 32'sh7FFF_FFFF;
            fin_status <= lie_pkg::ST_SAT;
          end else if (acc < -64'sh8000_0000) begin
            fin_value  <= 32'sh8000_0000;
            fin_status <= lie_pkg::ST_SAT;
          end else begin
            fin_value  <= acc[31:0];
            fin_status <= sat ? lie_pkg::ST_SAT : lie_pkg::ST_OK;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            result_value <= fin_value;
            status       <= fin_status;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never grows past its size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above table size");

  // bounds stay ordered while points are held
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> least_x <= greatest_x)
    else $error("least x above greatest x");

  // a non-zero value only comes with ok or saturated
  a_value_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_value != '0 |->
      (status == lie_pkg::ST_OK || status == lie_pkg::ST_SAT))
    else $error("value given with a rejecting status");

  // an accepted item leaves the sequencer busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held through an accepted item");

endmodule
